// ----- src/mpm_pkg.sv -----
package mpm_pkg;

   localparam int unsigned TARGET_W    = 8;
   localparam int unsigned LIMIT_W     = 32;
   localparam int unsigned TOTAL_W     = 32;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_DATA_W  = 8;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_TARGET = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_LIMIT = 8'd1;

   localparam logic [TARGET_W-1:0] PERIOD_TARGET_RESET = 8'd150;
   localparam logic [LIMIT_W-1:0]  TIMEOUT_LIMIT_RESET = 32'd10000000;

   localparam logic [TOTAL_W-1:0]  TOTAL_MAX = '1;

endpackage

// ----- src/multi_period_meter_with_timeout.sv -----
// A result appears on rsp once the tick that ends it has passed through the input register
// and then the result register.
// Throughput: one tick per cycle; req_tready falls only while the result register is full
// and rsp_tready is low.
// Reset (synchronous, active high): phase idle, counters zero, both registers at their
// defaults (period_target 150, timeout_limit 10000000), no result pending.
module multi_period_meter_with_timeout #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // tick input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mpm_pkg::REQ_DATA_W-1:0]    req_tdata,   // [0] pin_level, rest zero
   input  logic                              req_tuser,   // [0] cmd (1 = start)
   // measurement result
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mpm_pkg::TOTAL_W-1:0]       rsp_tdata,   // [31:0] tick_total
   output logic                              rsp_tuser,   // [0] timed_out
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mpm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mpm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mpm_pkg::*;

   // comparison width: wide enough for both the counter and the limit
   localparam int unsigned CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT_LOW,
      PH_WAIT_HIGH,
      PH_MEAS_LOW,
      PH_MEAS_HIGH
   } phase_type;

   // ---------------- configuration ----------------
   logic [TARGET_W-1:0] period_target_ff;
   logic [LIMIT_W-1:0]  timeout_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_target_ff <= PERIOD_TARGET_RESET;
         timeout_limit_ff <= TIMEOUT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PERIOD_TARGET: period_target_ff <= csr_data[TARGET_W-1:0];
            CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_data[LIMIT_W-1:0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   // ---------------- input register ----------------
   logic in_valid_ff;
   logic in_cmd_ff;
   logic in_pin_ff;
   logic out_valid_ff;
   logic advance;

   // the registered tick moves on when the result slot is free or drains this cycle
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff <= req_tuser;
         in_pin_ff <= req_tdata[0];
      end
   end

   // ---------------- measurement state ----------------
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [TARGET_W-1:0]    periods_done_ff, periods_done_in;
   logic [TOTAL_W-1:0]     out_total_ff;
   logic                   out_flag_ff;

   logic [COUNT_WIDTH-1:0] bumped;
   logic [TARGET_W-1:0]    periods_next;
   logic                   over_limit;
   logic                   emit;
   logic [TOTAL_W-1:0]     total;
   logic                   flag;
   logic [CMP_W-1:0]       bumped_ext;

   // counter saturates at all ones
   assign bumped       = (&tick_count_ff) ? tick_count_ff : tick_count_ff + 1'b1;
   assign bumped_ext   = CMP_W'(bumped);
   assign over_limit   = bumped_ext > CMP_W'(timeout_limit_ff);
   assign periods_next = periods_done_ff + 1'b1;

   always_comb begin
      phase_in        = phase_ff;
      tick_count_in   = tick_count_ff;
      periods_done_in = periods_done_ff;
      emit            = 1'b0;
      total           = '0;
      flag            = 1'b0;
      if (in_cmd_ff) begin
         // start: abandon any run, pin ignored on this tick
         phase_in        = PH_WAIT_LOW;
         tick_count_in   = '0;
         periods_done_in = '0;
      end else begin
         case (phase_ff)
            PH_WAIT_LOW: begin
               if (!in_pin_ff) begin
                  phase_in      = PH_WAIT_HIGH;
                  tick_count_in = '0;
               end else begin
                  tick_count_in = bumped;
                  if (over_limit) begin
                     emit     = 1'b1;
                     flag     = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_WAIT_HIGH: begin
               if (in_pin_ff) begin
                  // first rising edge: timing starts here
                  tick_count_in   = '0;
                  periods_done_in = '0;
                  if (period_target_ff == '0) begin
                     emit     = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_MEAS_LOW;
                  end
               end else begin
                  tick_count_in = bumped;
                  if (over_limit) begin
                     emit     = 1'b1;
                     flag     = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_MEAS_LOW: begin
               tick_count_in = bumped;
               if (!in_pin_ff) begin
                  phase_in = PH_MEAS_HIGH;
               end else if (over_limit) begin
                  emit     = 1'b1;
                  flag     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            PH_MEAS_HIGH: begin
               tick_count_in = bumped;
               if (in_pin_ff) begin
                  periods_done_in = periods_next;
                  if (periods_next >= period_target_ff) begin
                     emit     = 1'b1;
                     phase_in = PH_IDLE;
                     // report counts beyond the result width as all ones
                     total    = (bumped_ext > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                : bumped_ext[TOTAL_W-1:0];
                  end else begin
                     phase_in = PH_MEAS_LOW;
                  end
               end else if (over_limit) begin
                  emit     = 1'b1;
                  flag     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // state and result register move together on each processed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         tick_count_ff   <= '0;
         periods_done_ff <= '0;
         out_valid_ff    <= 1'b0;
         out_total_ff    <= '0;
         out_flag_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         tick_count_ff   <= tick_count_in;
         periods_done_ff <= periods_done_in;
         out_valid_ff    <= emit;
         if (emit) begin
            out_total_ff <= total;
            out_flag_ff  <= flag;
         end
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // ---------------- result register ----------------
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_total_ff;
   assign rsp_tuser  = out_flag_ff;

   // ---------------- assertions ----------------
   // a result only comes out of a running measurement on a plain tick
   assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |-> (!in_cmd_ff && phase_ff != PH_IDLE))
      else $error("result emitted outside a measurement");

   // a timeout result always carries a zero total
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("timeout result with nonzero total");

   // input side stalls only behind a blocked, full result register
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without back-pressure");

   // a processed start tick always arms the wait for a low level
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_cmd_ff) |=> (phase_ff == PH_WAIT_LOW))
      else $error("start did not enter wait-low");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import mpm_pkg::*;

   localparam int unsigned COUNT_WIDTH   = 32;
   localparam int unsigned TICK_GOAL     = 1950;  // ticks offered before the stimulus stops
   localparam int unsigned QUIET_TAIL    = 300;   // last ticks run with no idling at all
   localparam int unsigned SETTLE_CYCLES = 4;     // margin for the input and result registers to empty
   localparam int unsigned HOLD_CYCLES   = 120;   // long receiver hold-off
   localparam int unsigned PRINT_CAP     = 50;

   // Predictor phases, same meaning as the block's own phase register
   typedef enum logic [2:0] {
      METER_IDLE,
      METER_AWAIT_LOW,
      METER_AWAIT_HIGH,
      METER_COUNT_LOW,
      METER_COUNT_HIGH
   } meter_phase_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic               timed_out;
   } meter_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // [0] pin_level, rest zero
   logic                   req_tuser;   // [0] cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [TOTAL_W-1:0]     rsp_tdata;   // [31:0] tick_total
   logic                   rsp_tuser;   // [0] timed_out
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Predictor state and its copy of the registers
   meter_phase_type        meter_phase;
   logic [COUNT_WIDTH-1:0] tick_cnt;
   logic [TARGET_W-1:0]    periods_cnt;
   logic [TARGET_W-1:0]    target_reg;
   logic [LIMIT_W-1:0]     limit_reg;

   meter_result_type pending_results[$];  // totals still owed by the block, oldest first
   int unsigned   sent_ticks;
   int unsigned   mismatch_count;
   bit            gaps_on;             // sender may pause between transfers
   bit            stalls_on;           // receiver may drop rsp_tready
   bit            hold_off_request;    // asks the receiver for one long hold-off

   always #5 clock = ~clock;

   multi_period_meter_with_timeout #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------- predictor

   function automatic void close_run(logic [COUNT_WIDTH-1:0] total, bit flag);
      meter_result_type r;
      r.total     = total;  // counter is no wider than the result field
      r.timed_out = flag;
      pending_results.push_back(r);
      meter_phase = METER_IDLE;
   endfunction

   // counter saturates instead of wrapping
   function automatic void bump_count();
      if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
   endfunction

   function automatic void check_limit();
      if (tick_cnt > limit_reg) close_run('0, 1'b1);
   endfunction

   // One accepted tick. In every waiting phase a level change wins over the timeout.
   function automatic void meter_predict(bit start, bit pin);
      if (start) begin
         // restart: any running measurement is dropped without a result
         meter_phase = METER_AWAIT_LOW;
         tick_cnt    = '0;
         periods_cnt = '0;
         return;
      end
      case (meter_phase)
         METER_AWAIT_LOW: begin
            if (!pin) begin
               meter_phase = METER_AWAIT_HIGH;
               tick_cnt    = '0;
            end else begin
               bump_count();
               check_limit();
            end
         end
         METER_AWAIT_HIGH: begin
            if (pin) begin
               // first rising edge: measurement window opens here
               tick_cnt    = '0;
               periods_cnt = '0;
               if (target_reg == '0) close_run('0, 1'b0);
               else meter_phase = METER_COUNT_LOW;
            end else begin
               bump_count();
               check_limit();
            end
         end
         METER_COUNT_LOW: begin
            bump_count();
            if (!pin) meter_phase = METER_COUNT_HIGH;
            else check_limit();
         end
         METER_COUNT_HIGH: begin
            bump_count();
            if (pin) begin
               periods_cnt = periods_cnt + 1'b1;
               // a target lowered mid-run ends it at the next rising edge
               if (periods_cnt >= target_reg) close_run(tick_cnt, 1'b0);
               else meter_phase = METER_COUNT_LOW;
            end else begin
               check_limit();
            end
         end
         default: meter_phase = METER_IDLE;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   // Every result transfer is compared against the oldest expected total.
   always @(posedge clock) begin : check_results
      meter_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, tick_total", 64'd0, 64'(rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.total)
               report_mismatch("tick_total", 64'(want.total), 64'(rsp_tdata));
            if (rsp_tuser !== want.timed_out)
               report_mismatch("timed_out", 64'(want.timed_out), 64'(rsp_tuser));
         end
      end
   end

   // Receiver: random stall bursts, or one long hold-off counted here on request.
   initial begin : receiver
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog for a hung handshake
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   // One tick transfer. tvalid stays high between back-to-back ticks.
   task automatic send_tick(bit cmd, bit pin);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(pin);
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      meter_predict(cmd, pin);
      sent_ticks++;
   endtask

   task automatic send_level(bit pin, int unsigned n);
      repeat (n) send_tick(1'b0, pin);
   endtask

   // Stop offering ticks, wait for every owed result, then let the pipeline empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid is left high; the caller lowers it after the last write.
   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_PERIOD_TARGET) target_reg = data[TARGET_W-1:0];
      else if (index == CSR_TIMEOUT_LIMIT) limit_reg = data[LIMIT_W-1:0];
   endtask

   // Register writes only once the block has gone quiet.
   task automatic apply_settings(logic [TARGET_W-1:0] target, logic [LIMIT_W-1:0] limit,
                                 bit poke_unused);
      settle();
      // upper data bits are junk for the 8-bit target
      csr_write(CSR_PERIOD_TARGET, ($urandom() & ~32'hFF) | CSR_DATA_W'(target));
      csr_write(CSR_TIMEOUT_LIMIT, limit);
      if (poke_unused)
         csr_write(CSR_INDEX_W'($urandom_range(CSR_TIMEOUT_LIMIT + 1,
                                               (2 ** CSR_INDEX_W) - 1)), $urandom());
      csr_valid <= 1'b0;
   endtask

   function automatic int unsigned level_len(int unsigned max_len);
      if (max_len > 1 && $urandom_range(0, 9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, max_len);
   endfunction

   // Well-formed run: start, optional high lead-in, low, first rise, then periods.
   // Sometimes cut short so the next start abandons it.
   task automatic run_measurement(int unsigned max_len);
      int unsigned periods;
      send_tick(1'b1, 1'($urandom_range(0, 1)));  // pin ignored on a start
      send_level(1'b1, $urandom_range(0, 3));
      send_level(1'b0, level_len(max_len));
      send_level(1'b1, level_len(max_len));
      if ($urandom_range(0, 7) == 0) periods = $urandom_range(0, target_reg);
      else periods = target_reg + $urandom_range(0, 1);
      repeat (periods) begin
         send_level(1'b0, level_len(max_len));
         send_level(1'b1, level_len(max_len));
      end
   endtask

   // Broken sequences: random pin with an occasional start mixed in
   task automatic send_noise();
      repeat ($urandom_range(1, 12))
         send_tick($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_idle_ticks();
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
   endtask

   // Registers untouched since reset: a target of 150 periods against the large default limit
   task automatic test_reset_defaults();
      run_measurement(2);
   endtask

   task automatic test_zero_target();
      apply_settings('0, '1, 1'b0);
      send_tick(1'b1, 1'b0);
      send_level(1'b1, 2);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);     // first rise reports zero at once
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
   endtask

   task automatic test_timeouts();
      apply_settings(8'd2, '0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);     // waiting for low, count 1 passes limit 0
      apply_settings(8'd2, 32'd3, 1'b0);
      send_tick(1'b1, 1'b0);
      send_level(1'b0, 5);       // waiting for high runs out
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_level(1'b1, 5);       // measuring low level runs out
      // level change at count 4 wins over the limit of 3
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_level(1'b1, 4);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      // running measurement abandoned by a new start, then timeout while high
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_level(1'b1, 5);
   endtask

   task automatic test_target_change();
      apply_settings(8'd5, '1, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      repeat (3) begin
         send_tick(1'b0, 1'b0);
         send_tick(1'b0, 1'b1);
      end
      // target lowered below periods already done
      apply_settings(8'd2, '1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
   endtask

   // Receiver holds off while zero-target runs keep producing results.
   task automatic test_backpressure();
      apply_settings('0, '1, 1'b0);
      hold_off_request = 1'b1;
      repeat (40) begin
         send_tick(1'b1, 1'b1);
         send_tick(1'b0, 1'b0);
         send_tick(1'b0, 1'b1);
      end
   endtask

   task automatic test_random_measurements();
      logic [TARGET_W-1:0] target;
      logic [LIMIT_W-1:0]  limit;
      int unsigned         phase_end;
      int unsigned         max_len;
      bit                  first = 1'b1;
      while (sent_ticks < TICK_GOAL) begin
         if (first) begin
            target = '1;  // widest target once, with the widest limit
            limit  = '1;
            first  = 1'b0;
         end else begin
            case ($urandom_range(0, 4))
               0:       target = '0;
               1:       target = 8'd1;
               default: target = TARGET_W'($urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 4))
               0:       limit = '0;
               1:       limit = $urandom_range(1, 12);
               2:       limit = $urandom_range(13, 80);
               3:       limit = '1;
               default: limit = $urandom();
            endcase
         end
         apply_settings(target, limit, $urandom_range(0, 3) == 0);
         max_len   = (target > 16) ? 1 : 6;
         gaps_on   = $urandom_range(0, 3) != 0;
         stalls_on = $urandom_range(0, 3) != 0;
         phase_end = sent_ticks + 180;
         while (sent_ticks < phase_end && sent_ticks < TICK_GOAL) begin
            if (sent_ticks + QUIET_TAIL >= TICK_GOAL) begin
               gaps_on   = 1'b0;
               stalls_on = 1'b0;
            end
            if ($urandom_range(0, 4) == 0) send_noise();
            else run_measurement(max_len);
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset            <= 1'b1;
      req_tvalid       <= 1'b0;
      req_tdata        <= '0;
      req_tuser        <= 1'b0;
      csr_valid        <= 1'b0;
      csr_index        <= '0;
      csr_data         <= '0;
      gaps_on          = 1'b0;
      stalls_on        = 1'b0;
      hold_off_request = 1'b0;
      sent_ticks       = 0;
      mismatch_count   = 0;
      meter_phase      = METER_IDLE;
      tick_cnt         = '0;
      periods_cnt      = '0;
      target_reg       = PERIOD_TARGET_RESET;
      limit_reg        = TIMEOUT_LIMIT_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      test_idle_ticks();
      test_reset_defaults();
      test_zero_target();
      test_timeouts();
      test_target_change();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      test_backpressure();
      test_random_measurements();

      settle();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", 64'(pending_results.size()), 64'd0);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
